@@ design/sadsd_pkg.sv @@
`default_nettype none
package sadsd_pkg;

  localparam int MaxWidth      = 1024;
  localparam int MaxHeight     = 1024;
  localparam int MaxDisparity  = 64;
  localparam int MaxHalfWindow = 7;
  localparam int StoreDepth    = (2 * MaxHalfWindow + 2) * MaxWidth + MaxDisparity;
  localparam int StoreAw       = $clog2(StoreDepth);
  localparam int FifoDepth     = 4;

  typedef enum logic {
    OP_PIXEL,
    OP_FLUSH
  } op_e;

  typedef enum logic [1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_DISP_COUNT,
    REG_HALF
  } reg_idx_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] left_pixel;
    logic [7:0] right_pixel;
  } item_t;

  typedef struct packed {
    logic [5:0]  disparity;
    logic [15:0] match_cost;
    logic        last_of_frame;
  } result_t;

  // clamped configuration as the datapath sees it
  typedef struct packed {
    logic [10:0] width;
    logic [10:0] height;
    logic [6:0]  disp_count;
    logic [2:0]  half;
  } cfg_t;

  typedef struct packed {
    logic [9:0]         row;
    logic [9:0]         col;
    logic [StoreAw-1:0] addr;
    logic               last;
  } job_t;

  typedef struct packed {
    logic               en;
    logic [StoreAw-1:0] addr;
    logic [7:0]         left;
    logic [7:0]         right;
  } store_wr_t;

  typedef struct packed {
    logic [StoreAw-1:0] left_addr;
    logic [StoreAw-1:0] right_addr;
  } store_rd_t;

endpackage
`default_nettype wire

@@ design/sadsd_ram.sv @@
`default_nettype none
module sadsd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ design/sadsd_fifo.sv @@
`default_nettype none
module sadsd_fifo
  import sadsd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      data_o,
  output logic      empty_o
);

  localparam int Pw = $clog2(FifoDepth);

  job_t          slot_q [FifoDepth];
  logic [Pw-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [Pw:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (Pw+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = do_push ? ((wptr_q == Pw'(FifoDepth-1)) ? '0 : wptr_q + 1'b1) : wptr_q;
    rptr_d = do_pop ? ((rptr_q == Pw'(FifoDepth-1)) ? '0 : rptr_q + 1'b1) : rptr_q;
    cnt_d  = cnt_q + (Pw+1)'(do_push) - (Pw+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

@@ design/sadsd_front.sv @@
`default_nettype none
module sadsd_front
  import sadsd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic cfg_wr_i,
  input  wire logic push_i,
  output logic      full_o,
  input  item_t     item_i,
  output logic      job_push_o,
  output job_t      job_o,
  input  wire logic job_full_i,
  output store_wr_t wr_o
);

  localparam logic [StoreAw-1:0] StoreLast = StoreAw'(StoreDepth - 1);

  logic [10:0]        in_row_q, in_row_d;
  logic [9:0]         in_col_q, in_col_d;
  logic [20:0]        pos_q, pos_d;
  logic [StoreAw-1:0] wr_addr_q, wr_addr_d;
  logic [9:0]         out_row_q, out_row_d;
  logic [9:0]         out_col_q, out_col_d;
  logic [StoreAw-1:0] out_addr_q, out_addr_d;

  logic        accept, pix, emit, last, in_col_end, out_col_end;
  logic [13:0] w14, k14, lag;

  assign full_o = job_full_i;
  assign accept = push_i && !job_full_i;
  assign w14    = 14'(cfg_i.width);
  assign k14    = 14'(cfg_i.half);
  assign lag    = w14 * k14 + k14;

  assign pix  = accept && (item_i.op == OP_PIXEL) && (in_row_q < cfg_i.height);
  assign emit = (pix && (pos_q >= 21'(lag)))
             || (accept && (item_i.op == OP_FLUSH) && (in_row_q >= cfg_i.height));

  assign in_col_end  = ({1'b0, in_col_q} == cfg_i.width - 11'd1);
  assign out_col_end = ({1'b0, out_col_q} == cfg_i.width - 11'd1);
  assign last = out_col_end && ({1'b0, out_row_q} == cfg_i.height - 11'd1);

  assign wr_o.en    = pix;
  assign wr_o.addr  = wr_addr_q;
  assign wr_o.left  = item_i.left_pixel;
  assign wr_o.right = item_i.right_pixel;

  assign job_push_o = emit;
  assign job_o.row  = out_row_q;
  assign job_o.col  = out_col_q;
  assign job_o.addr = out_addr_q;
  assign job_o.last = last;

  always_comb begin
    in_row_d   = in_row_q;
    in_col_d   = in_col_q;
    pos_d      = pos_q;
    wr_addr_d  = wr_addr_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_addr_d = out_addr_q;
    if (pix) begin
      pos_d     = pos_q + 21'd1;
      wr_addr_d = (wr_addr_q == StoreLast) ? '0 : wr_addr_q + 1'b1;
      if (in_col_end) begin
        in_col_d = '0;
        in_row_d = in_row_q + 11'd1;
      end else begin
        in_col_d = in_col_q + 10'd1;
      end
    end
    if (emit) begin
      out_addr_d = (out_addr_q == StoreLast) ? '0 : out_addr_q + 1'b1;
      if (out_col_end) begin
        out_col_d = '0;
        out_row_d = out_row_q + 10'd1;
      end else begin
        out_col_d = out_col_q + 10'd1;
      end
    end
    // frame done or reconfigured: restart at the origin
    if (cfg_wr_i || (emit && last)) begin
      in_row_d   = '0;
      in_col_d   = '0;
      pos_d      = '0;
      wr_addr_d  = '0;
      out_row_d  = '0;
      out_col_d  = '0;
      out_addr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      pos_q      <= '0;
      wr_addr_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_addr_q <= '0;
    end else begin
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      pos_q      <= pos_d;
      wr_addr_q  <= wr_addr_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_addr_q <= out_addr_d;
    end
  end

endmodule
`default_nettype wire

@@ design/sadsd_back.sv @@
`default_nettype none
module sadsd_back
  import sadsd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  cfg_t            cfg_i,
  input  job_t            job_i,
  input  wire logic       job_empty_i,
  output logic            job_pop_o,
  output store_rd_t       rd_o,
  input  wire logic [7:0] left_data_i,
  input  wire logic [7:0] right_data_i,
  output logic            res_valid_o,
  output result_t         res_o,
  input  wire logic       res_pop_i
);

  localparam logic [StoreAw:0] Depth = (StoreAw+1)'(StoreDepth);

  // tap issue stage
  logic               busy_q, busy_d;
  job_t               job_q;
  logic [5:0]         d_q, d_d;
  logic signed [4:0]  i_q, i_d, j_q, j_d;
  logic [StoreAw-1:0] base_q, base_d, rb_q, rb_d, la_q, la_d;
  // accumulate stage
  logic               b_vld_q, b_ok_q, b_end_q, b_last_q, b_first_q;
  logic [5:0]         b_d_q;
  logic [15:0]        acc_q, acc_d, best_q, best_d;
  logic [5:0]         best_disp_q, best_disp_d;
  logic               out_vld_q, out_vld_d;
  result_t            out_q, out_d;

  logic               start, ok, row_end, win_end, more_d, tap_last;
  logic signed [4:0]  ks;
  logic signed [12:0] rr, cc, ccd;
  logic [6:0]         dn;
  logic [13:0]        off;
  logic [StoreAw:0]   la_inc, rb_inc, ra_sum, base_sum;
  logic [StoreAw-1:0] ra, la_next, rb_next, base_new;
  logic [7:0]         ad;
  logic [15:0]        sum;
  logic               better;

  assign ks    = signed'({2'b00, cfg_i.half});
  assign start = !busy_q && !b_vld_q && !out_vld_q && !job_empty_i;
  assign job_pop_o = start;

  // window origin, wrapped into the store
  assign off      = 14'(cfg_i.half) * 14'(cfg_i.width) + 14'(cfg_i.half);
  assign base_sum = {1'b0, job_i.addr} + Depth - (StoreAw+1)'(off);
  assign base_new = (base_sum >= Depth) ? StoreAw'(base_sum - Depth) : StoreAw'(base_sum);

  assign rr  = signed'({3'b000, job_q.row}) + 13'(i_q);
  assign cc  = signed'({3'b000, job_q.col}) + 13'(j_q);
  assign ccd = cc - signed'({7'b0, d_q});
  assign ok  = (rr >= 0) && (rr < signed'({2'b00, cfg_i.height}))
            && (cc >= 0) && (cc < signed'({2'b00, cfg_i.width})) && (ccd >= 0);

  assign row_end  = (j_q == ks);
  assign win_end  = row_end && (i_q == ks);
  assign dn       = 7'(d_q) + 7'd1;
  assign more_d   = (dn < cfg_i.disp_count) && (10'(dn) <= job_q.col);
  assign tap_last = win_end && !more_d;

  assign la_inc  = {1'b0, la_q} + 1'b1;
  assign la_next = (la_inc >= Depth) ? StoreAw'(la_inc - Depth) : StoreAw'(la_inc);
  assign rb_inc  = {1'b0, rb_q} + (StoreAw+1)'(cfg_i.width);
  assign rb_next = (rb_inc >= Depth) ? StoreAw'(rb_inc - Depth) : StoreAw'(rb_inc);
  assign ra_sum  = {1'b0, la_q} + Depth - (StoreAw+1)'(d_q);
  assign ra      = (ra_sum >= Depth) ? StoreAw'(ra_sum - Depth) : StoreAw'(ra_sum);

  assign rd_o.left_addr  = la_q;
  assign rd_o.right_addr = ra;

  always_comb begin
    busy_d = busy_q;
    d_d    = d_q;
    i_d    = i_q;
    j_d    = j_q;
    base_d = base_q;
    rb_d   = rb_q;
    la_d   = la_q;
    if (start) begin
      busy_d = 1'b1;
      d_d    = '0;
      i_d    = -ks;
      j_d    = -ks;
      base_d = base_new;
      rb_d   = base_new;
      la_d   = base_new;
    end else if (busy_q) begin
      if (!row_end) begin
        j_d  = j_q + 5'sd1;
        la_d = la_next;
      end else if (!win_end) begin
        j_d  = -ks;
        i_d  = i_q + 5'sd1;
        rb_d = rb_next;
        la_d = rb_next;
      end else begin
        d_d  = d_q + 6'd1;
        i_d  = -ks;
        j_d  = -ks;
        rb_d = base_q;
        la_d = base_q;
      end
      if (tap_last) begin
        busy_d = 1'b0;
      end
    end
  end

  assign ad     = (left_data_i > right_data_i) ? left_data_i - right_data_i
                                               : right_data_i - left_data_i;
  assign sum    = acc_q + (b_ok_q ? 16'(ad) : 16'd0);
  assign better = b_first_q || (sum < best_q);

  always_comb begin
    acc_d       = acc_q;
    best_d      = best_q;
    best_disp_d = best_disp_q;
    out_vld_d   = out_vld_q;
    out_d       = out_q;
    if (start) begin
      acc_d = '0;
    end else if (b_vld_q) begin
      if (b_end_q) begin
        acc_d = '0;
        if (better) begin
          best_d      = sum;
          best_disp_d = b_d_q;
        end
      end else begin
        acc_d = sum;
      end
    end
    if (res_pop_i && out_vld_q) begin
      out_vld_d = 1'b0;
    end
    if (b_vld_q && b_last_q) begin
      out_vld_d               = 1'b1;
      out_d.match_cost        = better ? sum : best_q;
      out_d.disparity         = better ? b_d_q : best_disp_q;
      out_d.last_of_frame     = job_q.last;
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      busy_q    <= busy_d;
      b_vld_q   <= busy_q;
      out_vld_q <= out_vld_d;
      acc_q     <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      job_q <= job_i;
    end
    d_q         <= d_d;
    i_q         <= i_d;
    j_q         <= j_d;
    base_q      <= base_d;
    rb_q        <= rb_d;
    la_q        <= la_d;
    b_ok_q      <= ok;
    b_end_q     <= win_end;
    b_last_q    <= tap_last;
    b_first_q   <= (d_q == '0);
    b_d_q       <= d_q;
    best_q      <= best_d;
    best_disp_q <= best_disp_d;
    out_q       <= out_d;
  end

endmodule
`default_nettype wire

@@ design/sad_stereo_disparity_core.sv @@
// SAD block-matching stereo core. Push left/right pixel pairs in raster order, then
// flush words after the frame to drain the trailing results; each result carries the
// winning disparity, its window cost and a frame-end flag. The input side stores pixels
// at one word per cycle until its four-entry job queue fills. For each result the
// back end starts the job, reads one window tap per cycle through the single read
// port of each line store for every disparity tried for that pixel, folds the last
// tap and holds the result until it is popped; it starts no new job while a result
// waits. A register write restarts the frame.
`default_nettype none
module sad_stereo_disparity_core
  import sadsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        push,
  output logic             full,
  input  item_t            item_i,
  output logic             empty,
  input  wire logic        pop,
  output result_t          result_o
);

  logic [10:0] width_q, height_q;
  logic [6:0]  disp_q;
  logic [2:0]  half_q;
  logic        cfg_wr;
  reg_idx_e    idx;
  cfg_t        cfg;

  store_wr_t   wr;
  store_rd_t   rd;
  logic [7:0]  left_data, right_data;
  job_t        job_in, job_out;
  logic        job_push, job_full, job_pop, job_empty, res_valid;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (idx)
      REG_WIDTH:      prdata = 32'(width_q);
      REG_HEIGHT:     prdata = 32'(height_q);
      REG_DISP_COUNT: prdata = 32'(disp_q);
      REG_HALF:       prdata = 32'(half_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 11'd480;
      disp_q   <= 7'd16;
      half_q   <= 3'd2;
    end else if (cfg_wr) begin
      case (idx)
        REG_WIDTH:      width_q  <= pwdata[10:0];
        REG_HEIGHT:     height_q <= pwdata[10:0];
        REG_DISP_COUNT: disp_q   <= pwdata[6:0];
        REG_HALF:       half_q   <= pwdata[2:0];
        default:        ;
      endcase
    end
  end

  // clamp to the supported ranges
  assign cfg.width  = (width_q == '0) ? 11'd1 :
                      ((width_q > 11'(MaxWidth)) ? 11'(MaxWidth) : width_q);
  assign cfg.height = (height_q == '0) ? 11'd1 :
                      ((height_q > 11'(MaxHeight)) ? 11'(MaxHeight) : height_q);
  assign cfg.disp_count = (disp_q == '0) ? 7'd1 :
                          ((disp_q > 7'(MaxDisparity)) ? 7'(MaxDisparity) : disp_q);
  assign cfg.half   = (half_q > 3'(MaxHalfWindow)) ? 3'(MaxHalfWindow) : half_q;

  sadsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cfg_wr_i   (cfg_wr),
    .push_i     (push),
    .full_o     (full),
    .item_i     (item_i),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full),
    .wr_o       (wr)
  );

  sadsd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  sadsd_ram #(.Width(8), .Depth(StoreDepth)) u_left_store (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.left),
    .raddr_i (rd.left_addr),
    .rdata_o (left_data)
  );

  sadsd_ram #(.Width(8), .Depth(StoreDepth)) u_right_store (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.right),
    .raddr_i (rd.right_addr),
    .rdata_o (right_data)
  );

  sadsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .job_i        (job_out),
    .job_empty_i  (job_empty),
    .job_pop_o    (job_pop),
    .rd_o         (rd),
    .left_data_i  (left_data),
    .right_data_i (right_data),
    .res_valid_o  (res_valid),
    .res_o        (result_o),
    .res_pop_i    (pop)
  );

  assign empty = !res_valid;

`ifndef NO_ASSERTIONS
  a_job_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !job_empty) else $error("job popped from empty queue");

  a_job_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full) else $error("job pushed into full queue");

  a_store_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (push && !full)) else $error("store written without accepted word");
`endif

endmodule
`default_nettype wire
